[rtl/ntp_pkg.sv]
// Package for the numeric token parser: payload structs, phase and verdict
// codes, result kinds and the default fraction-digit limit.
// No dependencies.
package ntp_pkg;

    // Default limit on fraction digits; longer fractions are not a number
    localparam int DEF_MAX_FRAC_DIGITS = 11;

    // ASCII codes the scanner looks for
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_E_LO   = 8'h65;
    localparam logic [7:0] CH_E_UP   = 8'h45;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A_LO   = 8'h61;
    localparam logic [7:0] CH_Z_LO   = 8'h7A;
    localparam logic [7:0] CH_A_UP   = 8'h41;
    localparam logic [7:0] CH_Z_UP   = 8'h5A;

    // Digit value returned for a character that is no digit in any base
    localparam logic [5:0] NO_DIGIT  = 6'd36;
    localparam logic [5:0] RADIX_DEC = 6'd10;
    localparam logic [31:0] RADIX_MIN = 32'd2;
    localparam logic [31:0] RADIX_MAX = 32'd36;

    // Scanner position within the token
    typedef enum logic [3:0] {
        PH_START       = 4'd0,
        PH_SIGNED      = 4'd1,
        PH_POINT       = 4'd2,
        PH_INT         = 4'd3,
        PH_FRAC        = 4'd4,
        PH_RADIX_START = 4'd5,
        PH_RADIX       = 4'd6,
        PH_EXP_START   = 4'd7,
        PH_EXP_SIGNED  = 4'd8,
        PH_EXP         = 4'd9
    } t_phase;

    // Verdict fixed early by a bad or trailing character
    typedef enum logic [1:0] {
        VF_NONE = 2'd0,
        VF_NAN  = 2'd1,
        VF_INT  = 2'd2,
        VF_REAL = 2'd3
    } t_verdict;

    // Result kind
    typedef enum logic [1:0] {
        KIND_NAN  = 2'd0,
        KIND_INT  = 2'd1,
        KIND_REAL = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_tok_in;

    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] int_value;
        logic signed [63:0] significand;
        logic signed [31:0] decimal_exponent;
    } t_tok_out;

endpackage

[rtl/numeric_token_parser.sv]
// Numeric token parser top level: input register, scanner state, result register.
// Depends on ntp_pkg.

// Takes one character per request and gives one verdict request per token, on
// the character flagged last. A character is registered on acceptance and
// scanned from the input register; the result of a token is loaded into the
// output register when its last character is scanned, raising o_out_valid.
// One character is taken every cycle unless a last character stalls; the scan
// stage holds the radix multiply-accumulate (32 x 6 bits), the 64-bit decimal
// shift-add and the sign handling of the result. Only a last character waits on
// a full output register; other characters keep flowing while a result is pending.
module numeric_token_parser #(
    parameter int MAX_FRAC_DIGITS = ntp_pkg::DEF_MAX_FRAC_DIGITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ntp_pkg::t_tok_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ntp_pkg::t_tok_out o_out_data
);
    import ntp_pkg::*;

    localparam int FW = $clog2(MAX_FRAC_DIGITS + 1);

    // Input register
    logic    r_in_valid;
    t_tok_in r_in;

    // Scanner state and next values
    t_phase        r_phase, n_phase;
    t_verdict      r_verdict, n_verdict;
    logic          r_negative, n_negative;
    logic          r_exp_negative, n_exp_negative;
    logic [31:0]   r_int_accum, n_int_accum;
    logic [63:0]   r_sig_accum, n_sig_accum;
    logic [FW-1:0] r_frac_count, n_frac_count;
    logic [31:0]   r_exp_accum, n_exp_accum;
    logic [5:0]    r_radix, n_radix;

    // Output register
    logic     r_out_valid;
    t_tok_out r_out, n_out;

    logic       proc_en;
    logic [7:0] c;
    logic       is_dec;
    logic [3:0] dec_val;
    logic [5:0] dig_val;
    logic       is_exp_ch;
    logic [31:0] int_dec, exp_dec, int_rad;
    logic [63:0] sig_dec;
    t_verdict    final_v;

    // Scan stage advances unless a last character meets a stalled result
    assign proc_en    = r_in_valid && (!r_in.last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || proc_en;

    // Character decode
    assign c         = r_in.character;
    assign is_dec    = (c >= CH_ZERO) && (c <= CH_NINE);
    assign dec_val   = 4'(c - CH_ZERO);
    assign is_exp_ch = (c == CH_E_LO) || (c == CH_E_UP);

    always_comb begin
        if (is_dec) begin
            dig_val = 6'(c - CH_ZERO);
        end else if ((c >= CH_A_LO) && (c <= CH_Z_LO)) begin
            dig_val = 6'(c - CH_A_LO) + 6'd10;
        end else if ((c >= CH_A_UP) && (c <= CH_Z_UP)) begin
            dig_val = 6'(c - CH_A_UP) + 6'd10;
        end else begin
            dig_val = NO_DIGIT;
        end
    end

    // Accumulator candidates: times ten by shift-add, times radix by multiply
    assign int_dec = (r_int_accum << 3) + (r_int_accum << 1) + {28'd0, dec_val};
    assign sig_dec = (r_sig_accum << 3) + (r_sig_accum << 1) + {60'd0, dec_val};
    assign exp_dec = (r_exp_accum << 3) + (r_exp_accum << 1) + {28'd0, dec_val};
    assign int_rad = 32'(r_int_accum * {26'd0, r_radix}) + {26'd0, dig_val};

    // Next state of the scanner
    always_comb begin
        n_phase        = r_phase;
        n_verdict      = r_verdict;
        n_negative     = r_negative;
        n_exp_negative = r_exp_negative;
        n_int_accum    = r_int_accum;
        n_sig_accum    = r_sig_accum;
        n_frac_count   = r_frac_count;
        n_exp_accum    = r_exp_accum;
        n_radix        = r_radix;
        if (r_verdict == VF_NONE) begin
            case (r_phase)
                PH_START, PH_SIGNED: begin
                    if ((r_phase == PH_START) && ((c == CH_PLUS) || (c == CH_MINUS))) begin
                        n_negative = (c == CH_MINUS);
                        n_phase    = PH_SIGNED;
                    end else if (c == CH_POINT) begin
                        n_phase = PH_POINT;
                    end else if (is_dec) begin
                        n_int_accum = int_dec;
                        n_sig_accum = sig_dec;
                        n_phase     = PH_INT;
                    end else begin
                        n_verdict = VF_NAN;
                    end
                end
                PH_POINT, PH_FRAC: begin
                    if (is_dec) begin
                        // fraction digit, limited by MAX_FRAC_DIGITS
                        if (r_frac_count >= FW'(MAX_FRAC_DIGITS)) begin
                            n_verdict = VF_NAN;
                        end else begin
                            n_sig_accum  = sig_dec;
                            n_frac_count = r_frac_count + 1'b1;
                            n_phase      = PH_FRAC;
                        end
                    end else if ((r_phase == PH_FRAC) && is_exp_ch) begin
                        n_phase = PH_EXP_START;
                    end else begin
                        n_verdict = VF_NAN;
                    end
                end
                PH_INT: begin
                    if (is_dec) begin
                        n_int_accum = int_dec;
                        n_sig_accum = sig_dec;
                    end else if (c == CH_POINT) begin
                        n_phase = PH_POINT;
                    end else if (c == CH_HASH) begin
                        if ((r_int_accum >= RADIX_MIN) && (r_int_accum <= RADIX_MAX)) begin
                            n_radix     = r_int_accum[5:0];
                            n_int_accum = '0;
                            n_phase     = PH_RADIX_START;
                        end else begin
                            n_verdict = VF_NAN;
                        end
                    end else if (is_exp_ch) begin
                        n_phase = PH_EXP_START;
                    end else begin
                        n_verdict = VF_NAN;
                    end
                end
                PH_RADIX_START, PH_RADIX: begin
                    // after one radix digit, trailing characters end the integer
                    if (dig_val < r_radix) begin
                        n_int_accum = int_rad;
                        n_phase     = PH_RADIX;
                    end else begin
                        n_verdict = (r_phase == PH_RADIX) ? VF_INT : VF_NAN;
                    end
                end
                PH_EXP_START: begin
                    if ((c == CH_PLUS) || (c == CH_MINUS)) begin
                        n_exp_negative = (c == CH_MINUS);
                        n_phase        = PH_EXP_SIGNED;
                    end else if (is_dec) begin
                        n_exp_accum = exp_dec;
                        n_phase     = PH_EXP;
                    end else begin
                        n_verdict = VF_NAN;
                    end
                end
                PH_EXP_SIGNED, PH_EXP: begin
                    // after one exponent digit, trailing characters end the real
                    if (is_dec) begin
                        n_exp_accum = exp_dec;
                        n_phase     = PH_EXP;
                    end else begin
                        n_verdict = (r_phase == PH_EXP) ? VF_REAL : VF_NAN;
                    end
                end
                default: begin
                    n_verdict = VF_NAN;
                end
            endcase
        end
    end

    // Verdict and result fields for a token that ends here
    always_comb begin
        final_v = n_verdict;
        if (n_verdict == VF_NONE) begin
            if ((n_phase == PH_INT) || (n_phase == PH_RADIX)) begin
                final_v = VF_INT;
            end else if ((n_phase == PH_FRAC) || (n_phase == PH_EXP)) begin
                final_v = VF_REAL;
            end else begin
                final_v = VF_NAN;
            end
        end
        n_out = '{kind: KIND_NAN, int_value: '0, significand: '0, decimal_exponent: '0};
        case (final_v)
            VF_INT: begin
                n_out.kind      = KIND_INT;
                n_out.int_value = n_negative ? -n_int_accum : n_int_accum;
            end
            VF_REAL: begin
                n_out.kind             = KIND_REAL;
                n_out.significand      = n_negative ? -n_sig_accum : n_sig_accum;
                n_out.decimal_exponent = (n_exp_negative ? -n_exp_accum : n_exp_accum)
                                         - {{(32-FW){1'b0}}, n_frac_count};
            end
            default: begin
                n_out.kind = KIND_NAN;
            end
        endcase
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Scanner state; back to token start after each last character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (proc_en && r_in.last)) begin
            r_phase        <= PH_START;
            r_verdict      <= VF_NONE;
            r_negative     <= 1'b0;
            r_exp_negative <= 1'b0;
            r_int_accum    <= '0;
            r_sig_accum    <= '0;
            r_frac_count   <= '0;
            r_exp_accum    <= '0;
            r_radix        <= RADIX_DEC;
        end else if (proc_en) begin
            r_phase        <= n_phase;
            r_verdict      <= n_verdict;
            r_negative     <= n_negative;
            r_exp_negative <= n_exp_negative;
            r_int_accum    <= n_int_accum;
            r_sig_accum    <= n_sig_accum;
            r_frac_count   <= n_frac_count;
            r_exp_accum    <= n_exp_accum;
            r_radix        <= n_radix;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_en && r_in.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (proc_en && r_in.last) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A scanned last character always leaves a result waiting
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_en && r_in.last) |=> r_out_valid)
        else $error("last character scanned without a result");

    // Scanner returns to token start after a last character
    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_en && r_in.last) |=> (r_phase == PH_START && r_verdict == VF_NONE
                                    && r_int_accum == '0 && r_sig_accum == '0))
        else $error("scanner state not cleared after token");

    // Fields of the other kind stay zero
    a_int_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind != KIND_INT) |-> (r_out.int_value == '0))
        else $error("int_value set on non-integer result");

    a_real_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind != KIND_REAL)
            |-> (r_out.significand == '0 && r_out.decimal_exponent == '0))
        else $error("real fields set on non-real result");

    // Fraction count never passes its limit
    a_frac_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> (r_frac_count <= FW'(MAX_FRAC_DIGITS)))
        else $error("fraction count beyond limit");

endmodule

[dv/tb_numeric_token_parser.sv]
// Testbench for numeric_token_parser: random and directed tokens sent one character per
// request, with every verdict checked against a cycle-free scanner model kept in a scoreboard.
// Depends on ntp_pkg and rtl/numeric_token_parser.sv.
`timescale 1ns / 100ps

module tb_numeric_token_parser;
    import ntp_pkg::*;

    localparam int          MAX_FRAC     = DEF_MAX_FRAC_DIGITS;
    localparam int unsigned RANDOM_CHARS = 1400;
    localparam int unsigned CALM_CHARS   = 400;
    localparam int unsigned TIMEOUT_NS   = 1_000_000;

    // Scanner model plus the queue of verdicts still owed by the block
    class verdict_scoreboard;
        t_tok_out    pending_verdicts[$];
        int unsigned mismatches;

        t_phase      phase;
        logic        negative;
        logic [31:0] int_acc;
        logic [63:0] sig_acc;
        logic [3:0]  frac_cnt;
        logic [31:0] exp_acc;
        logic        exp_neg;
        logic [5:0]  radix;
        t_verdict    fixed;

        function new();
            mismatches = 0;
            clear_token();
        endfunction

        function void clear_token();
            phase    = PH_START;
            negative = 1'b0;
            int_acc  = '0;
            sig_acc  = '0;
            frac_cnt = '0;
            exp_acc  = '0;
            exp_neg  = 1'b0;
            radix    = RADIX_DEC;
            fixed    = VF_NONE;
        endfunction

        function int outstanding();
            return pending_verdicts.size();
        endfunction

        function bit is_dec(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        // Digit value in any base up to 36, letters in either case
        function logic [5:0] digit_value(logic [7:0] c);
            if (c >= CH_ZERO && c <= CH_NINE) return 6'(c - CH_ZERO);
            if (c >= CH_A_LO && c <= CH_Z_LO) return 6'(c - CH_A_LO) + 6'd10;
            if (c >= CH_A_UP && c <= CH_Z_UP) return 6'(c - CH_A_UP) + 6'd10;
            return NO_DIGIT;
        endfunction

        function void int_digit(logic [7:0] c);
            int_acc = int_acc * 32'd10 + 32'(c - CH_ZERO);
            sig_acc = sig_acc * 64'd10 + 64'(c - CH_ZERO);
        endfunction

        // Fraction digits beyond the limit make the token not a number
        function void frac_digit(logic [7:0] c);
            if (frac_cnt >= MAX_FRAC) begin
                fixed = VF_NAN;
                return;
            end
            sig_acc  = sig_acc * 64'd10 + 64'(c - CH_ZERO);
            frac_cnt = frac_cnt + 4'd1;
            phase    = PH_FRAC;
        endfunction

        function void exp_digit(logic [7:0] c);
            exp_acc = exp_acc * 32'd10 + 32'(c - CH_ZERO);
            phase   = PH_EXP;
        endfunction

        // One character through the scanner
        function void scan_char(logic [7:0] c);
            logic [5:0] d;
            d = digit_value(c);
            case (phase)
                PH_START: begin
                    if (c == CH_PLUS || c == CH_MINUS) begin
                        negative = (c == CH_MINUS);
                        phase = PH_SIGNED;
                    end else if (c == CH_POINT) phase = PH_POINT;
                    else if (is_dec(c)) begin
                        int_digit(c);
                        phase = PH_INT;
                    end else fixed = VF_NAN;
                end
                PH_SIGNED: begin
                    if (c == CH_POINT) phase = PH_POINT;
                    else if (is_dec(c)) begin
                        int_digit(c);
                        phase = PH_INT;
                    end else fixed = VF_NAN;
                end
                PH_POINT: begin
                    if (is_dec(c)) frac_digit(c);
                    else fixed = VF_NAN;
                end
                PH_INT: begin
                    if (is_dec(c)) int_digit(c);
                    else if (c == CH_POINT) phase = PH_POINT;
                    else if (c == CH_HASH) begin
                        // base comes from the wrapped 32-bit value
                        if (int_acc >= RADIX_MIN && int_acc <= RADIX_MAX) begin
                            radix   = int_acc[5:0];
                            int_acc = '0;
                            phase   = PH_RADIX_START;
                        end else fixed = VF_NAN;
                    end else if (c == CH_E_LO || c == CH_E_UP) phase = PH_EXP_START;
                    else fixed = VF_NAN;
                end
                PH_FRAC: begin
                    if (is_dec(c)) frac_digit(c);
                    else if (c == CH_E_LO || c == CH_E_UP) phase = PH_EXP_START;
                    else fixed = VF_NAN;
                end
                PH_RADIX_START, PH_RADIX: begin
                    // junk after at least one radix digit ends the token as an integer
                    if (d < radix) begin
                        int_acc = int_acc * {26'd0, radix} + {26'd0, d};
                        phase   = PH_RADIX;
                    end else fixed = (phase == PH_RADIX) ? VF_INT : VF_NAN;
                end
                PH_EXP_START: begin
                    if (c == CH_PLUS || c == CH_MINUS) begin
                        exp_neg = (c == CH_MINUS);
                        phase = PH_EXP_SIGNED;
                    end else if (is_dec(c)) exp_digit(c);
                    else fixed = VF_NAN;
                end
                PH_EXP_SIGNED: begin
                    if (is_dec(c)) exp_digit(c);
                    else fixed = VF_NAN;
                end
                PH_EXP: begin
                    // junk after exponent digits ends the token as a real
                    if (is_dec(c)) exp_digit(c);
                    else fixed = VF_REAL;
                end
                default: fixed = VF_NAN;
            endcase
        endfunction

        // Accepted character; a last character queues the token's verdict
        function void note_request(t_tok_in req);
            t_verdict    v;
            t_tok_out    r;
            logic [31:0] e;
            if (fixed == VF_NONE) scan_char(req.character);
            if (!req.last) return;
            v = fixed;
            if (v == VF_NONE) begin
                if (phase == PH_INT || phase == PH_RADIX) v = VF_INT;
                else if (phase == PH_FRAC || phase == PH_EXP) v = VF_REAL;
                else v = VF_NAN;
            end
            r = '0;
            if (v == VF_INT) begin
                r.kind      = KIND_INT;
                r.int_value = negative ? -int_acc : int_acc;
            end else if (v == VF_REAL) begin
                e                  = exp_neg ? -exp_acc : exp_acc;
                r.kind             = KIND_REAL;
                r.significand      = negative ? -sig_acc : sig_acc;
                r.decimal_exponent = e - {28'd0, frac_cnt};
            end
            pending_verdicts.push_back(r);
            clear_token();
        endfunction

        function void compare_field(string name, logic signed [63:0] want,
                                    logic signed [63:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        // Verdict from the block against the oldest pending one
        function void check_result(t_tok_out got);
            t_tok_out want;
            if (pending_verdicts.size() == 0) begin
                $display("%0t: verdict with none pending: kind %0d int %0d sig %0d exp %0d",
                         $time, got.kind, got.int_value, got.significand,
                         got.decimal_exponent);
                mismatches++;
                return;
            end
            want = pending_verdicts.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("int_value", want.int_value, got.int_value);
            compare_field("significand", want.significand, got.significand);
            compare_field("decimal_exponent", want.decimal_exponent, got.decimal_exponent);
        endfunction
    endclass

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    t_tok_in  in_data   = '0;
    logic     out_ready = 1'b0;
    logic     in_ready;
    logic     out_valid;
    t_tok_out out_data;

    verdict_scoreboard sb;
    logic [7:0]        tok_bytes[$];
    bit                idle_en = 1'b1;
    int unsigned       stall_left = 0;

    string directed_toks[] = '{"-", ".", "2#", "1e-", "1#1", "36#Zz.", "1e5x", "-.5E+2", "9"};

    numeric_token_parser uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #1 clk = ~clk;

    // Receiver: ready, with random stall bursts while idling is enabled
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 14);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Verdict checking
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    end

    // Send tok_bytes as one token, with random sender gaps
    task automatic send_token();
        t_tok_in req;
        for (int i = 0; i < tok_bytes.size(); i++) begin
            req.character = tok_bytes[i];
            req.last      = (i == tok_bytes.size() - 1);
            if (idle_en && $urandom_range(0, 4) == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= req;
            do @(posedge clk); while (!in_ready);
            sb.note_request(req);
        end
    endtask

    // Hold the sender until the block owes nothing
    task automatic wait_verdicts();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
    endtask

    task automatic push_str(string s);
        for (int i = 0; i < s.len(); i++) tok_bytes.push_back(s[i]);
    endtask

    task automatic push_dec(int n);
        repeat (n) tok_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic push_sign(logic [7:0] plus, logic [7:0] minus);
        case ($urandom_range(0, 3))
            0: tok_bytes.push_back(plus);
            1: tok_bytes.push_back(minus);
            default: ;
        endcase
    endtask

    task automatic push_base_digit(int base);
        int d;
        d = $urandom_range(0, base - 1);
        if (d < 10) tok_bytes.push_back(CH_ZERO + 8'(d));
        else tok_bytes.push_back(($urandom_range(0, 1) ? CH_A_LO : CH_A_UP) + 8'(d - 10));
    endtask

    // Mostly well-formed tokens with random content, some noise and broken ones
    task automatic build_token();
        int n;
        int base;
        tok_bytes.delete();
        if ($urandom_range(0, 99) < 12) begin
            repeat ($urandom_range(1, 6)) tok_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        case ($urandom_range(0, 2))
            0: begin
                // decimal integer, sometimes long enough to wrap
                push_sign(CH_PLUS, CH_MINUS);
                push_dec(($urandom_range(0, 7) == 0) ? $urandom_range(10, 22)
                                                     : $urandom_range(1, 5));
            end
            1: begin
                // radix integer; a few bad bases and one that wraps to 2
                push_sign(CH_PLUS, CH_MINUS);
                base = $urandom_range(2, 36);
                case ($urandom_range(0, 11))
                    0: push_str("0");
                    1: push_str("37");
                    2: begin
                        push_str("4294967298");
                        base = 2;
                    end
                    3: push_str("1");
                    default: push_str($sformatf("%0d", base));
                endcase
                tok_bytes.push_back(CH_HASH);
                n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
                repeat (n) push_base_digit(base);
                if ($urandom_range(0, 3) == 0) tok_bytes.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
                // real: point and/or exponent, some long fractions and wide values
                push_sign(CH_PLUS, CH_MINUS);
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 3);
                push_dec(n);
                if (n == 0 || $urandom_range(0, 4) != 0) begin
                    tok_bytes.push_back(CH_POINT);
                    push_dec(($urandom_range(0, 5) == 0) ? $urandom_range(9, 14)
                                                         : $urandom_range(1, 5));
                end
                if ($urandom_range(0, 1)) begin
                    tok_bytes.push_back($urandom_range(0, 1) ? CH_E_LO : CH_E_UP);
                    push_sign(CH_PLUS, CH_MINUS);
                    push_dec(($urandom_range(0, 7) == 0) ? $urandom_range(10, 12)
                                                         : $urandom_range(1, 3));
                    if ($urandom_range(0, 4) == 0)
                        tok_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end
        endcase
        // occasionally truncate or corrupt a well-formed token
        if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1) && tok_bytes.size() > 1)
                repeat ($urandom_range(1, tok_bytes.size() - 1)) void'(tok_bytes.pop_back());
            else
                tok_bytes[$urandom_range(0, tok_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        end
    endtask

    // Run watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int unsigned chars_sent;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed tokens: incomplete, bad base, trailing junk, both byte extremes
        foreach (directed_toks[i]) begin
            tok_bytes.delete();
            push_str(directed_toks[i]);
            send_token();
        end
        tok_bytes = '{8'h00, 8'hFF};
        send_token();
        wait_verdicts();

        // random tokens; idling comes and goes, then stops for the last stretch
        chars_sent = 0;
        while (chars_sent < RANDOM_CHARS) begin
            build_token();
            send_token();
            chars_sent += tok_bytes.size();
            idle_en = (chars_sent < RANDOM_CHARS - CALM_CHARS) && ((chars_sent / 150) % 3 != 2);
        end
        wait_verdicts();
        repeat (8) @(posedge clk);
        @(negedge clk);

        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
